// File: sv/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants of the LZW dictionary compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwc_pkg;

  localparam logic [11:0] END_CODE      = 12'd256;
  localparam logic [12:0] FIRST_FREE    = 13'd257;
  localparam logic [11:0] MAX_CODE_RST  = 12'd1000;

  // dictionary generation tag, zero marks a swept entry
  localparam int EPOCH_W = 8;

  // front to back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // item classes decided by the front end
  localparam logic [1:0] CLS_FIRST     = 2'd0;
  localparam logic [1:0] CLS_BYTE      = 2'd1;
  localparam logic [1:0] CLS_END_FLUSH = 2'd2;
  localparam logic [1:0] CLS_END_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] data_byte;
  } q_item_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [11:0]        pfx;
    logic [7:0]         data_byte;
    logic [11:0]        code;
  } entry_t;

  // floor(log2(s))+1, and 1 for zero
  function automatic logic [3:0] code_width(input logic [11:0] s);
    logic [3:0] bits;
    bits = 4'd1;
    for (int i = 1; i < 12; i++) begin
      if (s[i]) begin
        bits = 4'(i + 1);
      end
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

// File: sv/lzw_dictionary_compressor.sv
// ----------------------------------------------------------------------------
// lzw_dictionary_compressor
// LZW compressor with fixed-width codes and a hashed, linearly probed dictionary.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    in_cmd, in_data_byte
//   out      output     out_valid/out_stall  out_code, out_code_bits, out_last
//   cfg      input      cfg_wr_en            cfg_max_code
//
// a byte that hits passes queue pop with hash, ram read and compare,
// plus a further probe of the dictionary ram per taken slot; a miss adds the emit and insert step
// end of stream emits the end code, after the pending prefix when one is flushed first
// after reset, and on every 255th dictionary clear, the ram is swept entry by entry;
// the 2-entry queue takes input meanwhile until it is full
// a stalled output holds the back end only when a result is ready to leave
// DICT_DEPTH must be a power of two
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_dictionary_compressor #(
  parameter int DICT_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [11:0] out_code,
  output logic      [3:0]  out_code_bits,
  output logic             out_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_max_code
);
  import lzwc_pkg::*;

  logic [11:0] max_code_r, max_code_nxt;
  logic [3:0]  code_bits_r, code_bits_nxt;
  logic        q_valid;
  logic        q_pop;
  q_item_t     q_item;

  always_comb begin
    max_code_nxt  = max_code_r;
    code_bits_nxt = code_bits_r;
    if (cfg_wr_en) begin
      max_code_nxt  = cfg_max_code;
      code_bits_nxt = code_width(cfg_max_code);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_code_r  <= MAX_CODE_RST;
      code_bits_r <= code_width(MAX_CODE_RST);
    end else begin
      max_code_r  <= max_code_nxt;
      code_bits_r <= code_bits_nxt;
    end
  end

  lzwc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item)
  );

  lzwc_back #(
    .DICT_DEPTH (DICT_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .max_code      (max_code_r),
    .code_bits     (code_bits_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code      (out_code),
    .out_code_bits (out_code_bits),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// File: sv/lzwc_ram.sv
// ----------------------------------------------------------------------------
// lzwc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/lzwc_front.sv
// ----------------------------------------------------------------------------
// lzwc_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_cmd,
  input  wire logic [7:0]        in_data_byte,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output lzwc_pkg::q_item_t      q_item
);
  import lzwc_pkg::*;

  q_item_t            q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]      count_r, count_nxt;
  logic               have_pfx_r, have_pfx_nxt;
  logic               push;
  q_item_t            new_item;

  assign in_stall = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // prefix tracking depends only on the command sequence
  always_comb begin
    new_item.data_byte = in_data_byte;
    if (in_cmd) begin
      new_item.cls = have_pfx_r ? CLS_END_FLUSH : CLS_END_EMPTY;
    end else begin
      new_item.cls = have_pfx_r ? CLS_BYTE : CLS_FIRST;
    end
  end

  always_comb begin
    wr_ptr_nxt   = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt   = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt    = count_r + (Q_AW+1)'(push) - (Q_AW+1)'(q_pop);
    have_pfx_nxt = push ? !in_cmd : have_pfx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
      have_pfx_r <= 1'b0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      count_r    <= count_nxt;
      have_pfx_r <= have_pfx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

// File: sv/lzwc_back.sv
// ----------------------------------------------------------------------------
// lzwc_back
// Dictionary probe and insert engine with the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_back #(
  parameter int DICT_DEPTH = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire lzwc_pkg::q_item_t q_item,
  input  wire logic [11:0]       max_code,
  input  wire logic [3:0]        code_bits,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [11:0]       out_code,
  output logic      [3:0]        out_code_bits,
  output logic                   out_last
);
  import lzwc_pkg::*;

  localparam int ADDR_W = $clog2(DICT_DEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_MISS  = 3'd4;
  localparam logic [2:0] ST_END1  = 3'd5;
  localparam logic [2:0] ST_END2  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [11:0]         prefix_r, prefix_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [12:0]         next_free_r, next_free_nxt;
  logic [ADDR_W-1:0]   slot_r, slot_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic                ins_r, ins_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [11:0]         out_code_r, out_code_nxt;
  logic [3:0]          out_bits_r, out_bits_nxt;
  logic                out_last_r, out_last_nxt;

  // ram side
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;

  // hash of the queued byte against the current prefix
  logic [19:0]         key;
  logic [35:0]         key_prod;
  logic [19:0]         key_shr;
  logic [ADDR_W-1:0]   hash_slot;

  logic                out_free;
  logic                emit;
  logic [11:0]         emit_code;
  logic                emit_last;
  logic                do_clear;
  logic                entry_empty, entry_hit;
  logic [12:0]         nf_inc;

  assign key       = {prefix_r, q_item.data_byte};
  assign key_prod  = 36'(key) * 36'd40503;
  assign key_shr   = {7'd0, key[19:7]};
  assign hash_slot = key_prod[ADDR_W-1:0] ^ key_shr[ADDR_W-1:0];

  assign out_free    = !out_valid_r || !out_stall;
  assign entry_empty = (ram_rdata.tag != epoch_r);
  assign entry_hit   = !entry_empty && (ram_rdata.pfx == prefix_r) &&
                       (ram_rdata.data_byte == byte_r);
  assign nf_inc      = next_free_r + 13'd1;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    epoch_nxt     = epoch_r;
    prefix_nxt    = prefix_r;
    byte_nxt      = byte_r;
    next_free_nxt = next_free_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    ins_nxt       = ins_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = '{tag: epoch_r, pfx: prefix_r, data_byte: byte_r,
                      code: next_free_r[11:0]};
    ram_re        = 1'b0;
    ram_raddr     = slot_r;
    emit          = 1'b0;
    emit_code     = prefix_r;
    emit_last     = 1'b0;
    do_clear      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == {ADDR_W{1'b1}}) begin
          epoch_nxt = EPOCH_W'(1);
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.cls)
            CLS_FIRST: begin
              prefix_nxt = {4'd0, q_item.data_byte};
            end
            CLS_BYTE: begin
              byte_nxt  = q_item.data_byte;
              slot_nxt  = hash_slot;
              cnt_nxt   = '0;
              state_nxt = ST_RD;
            end
            CLS_END_FLUSH: begin
              state_nxt = ST_END1;
            end
            default: begin
              state_nxt = ST_END2;
            end
          endcase
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (entry_hit) begin
          prefix_nxt = ram_rdata.code;
          state_nxt  = ST_IDLE;
        end else if (entry_empty) begin
          ins_nxt   = 1'b1;
          state_nxt = ST_MISS;
        end else if (cnt_r == {ADDR_W{1'b1}}) begin
          // every slot probed and taken: the pair is dropped
          ins_nxt   = 1'b0;
          state_nxt = ST_MISS;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = slot_r + 1'b1;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          emit       = 1'b1;
          ram_we     = ins_r;
          prefix_nxt = {4'd0, byte_r};
          state_nxt  = ST_IDLE;
          if (nf_inc > {1'b0, max_code}) begin
            do_clear = 1'b1;
          end else begin
            next_free_nxt = nf_inc;
          end
        end
      end
      ST_END1: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_END2;
        end
      end
      ST_END2: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_code  = END_CODE;
          emit_last  = 1'b1;
          prefix_nxt = '0;
          state_nxt  = ST_IDLE;
          do_clear   = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // dictionary clear: a new generation, or a sweep once the tags run out
    if (do_clear) begin
      next_free_nxt = FIRST_FREE;
      if (epoch_r == {EPOCH_W{1'b1}}) begin
        clr_addr_nxt = '0;
        state_nxt    = ST_CLEAR;
      end else begin
        epoch_nxt = epoch_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = emit_code;
      out_bits_nxt  = code_bits;
      out_last_nxt  = emit_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      epoch_r     <= '0;
      prefix_r    <= '0;
      next_free_r <= FIRST_FREE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      epoch_r     <= epoch_nxt;
      prefix_r    <= prefix_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    slot_r     <= slot_nxt;
    cnt_r      <= cnt_nxt;
    ins_r      <= ins_nxt;
    out_code_r <= out_code_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
  end

  lzwc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DICT_DEPTH)
  ) u_dict_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_code      = out_code_r;
  assign out_code_bits = out_bits_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// File: sv/lzwc_checker.sv
// ----------------------------------------------------------------------------
// lzwc_checker
// Port-level assertions for the LZW compressor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [11:0] out_code,
  input wire logic [3:0]  out_code_bits,
  input wire logic        out_last
);
  import lzwc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code) && $stable(out_last) &&
                               $stable(out_code_bits))
    else $error("output transaction changed while stalled");

  // end code and last travel together
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_code == END_CODE)
    else $error("last set on a code other than the end code");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_code != END_CODE)
    else $error("end code emitted without last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind lzw_dictionary_compressor lzwc_checker u_lzwc_checker (.*);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LZW dictionary compressor.
// A short table of byte and end-of-stream items opens the run, with the codes
// typed in where they are obvious. Random streams over small alphabets follow,
// under several max_code settings and sender/receiver idling patterns. Every
// output transaction is checked against the typed codes or an in-bench LZW encoder.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lzwc_pkg::*;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // long enough for a dictionary sweep plus a deep probe chain
  localparam int DRAIN_CYCLES = 5000;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 178;

  typedef struct packed {
    logic [11:0] code;
    logic [3:0]  bits;
    logic        last;
  } lzw_code_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data;
    logic        typed;
    logic [1:0]  n;
    logic [11:0] c0;
    logic        l0;
    logic [11:0] c1;
    logic        l1;
  } stim_row_t;

  // max_code is 1000 after reset, so typed codes carry 10 bits
  localparam stim_row_t DIRECTED [25] = '{
    '{CMD_END,  8'h00, 1'b1, 2'd1, END_CODE, 1'b1, 12'd0,    1'b0}, // empty stream
    '{CMD_BYTE, 8'h00, 1'b1, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0}, // first byte
    '{CMD_BYTE, 8'hFF, 1'b1, 2'd1, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h00, 1'b1, 2'd1, 12'd255,  1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'hFF, 1'b1, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0}, // hits 257
    '{CMD_END,  8'h00, 1'b1, 2'd2, 12'd257,  1'b0, END_CODE, 1'b1},
    '{CMD_END,  8'hFF, 1'b1, 2'd1, END_CODE, 1'b1, 12'd0,    1'b0}, // byte ignored
    '{CMD_BYTE, 8'h41, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h41, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h41, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h41, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h41, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h41, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h41, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h41, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_END,  8'h00, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'hA5, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h5A, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'hA5, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h5A, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'hA5, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h80, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h01, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_BYTE, 8'h7F, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0},
    '{CMD_END,  8'h00, 1'b0, 2'd0, 12'd0,    1'b0, 12'd0,    1'b0}
  };

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        in_cmd        = 1'b0;
  logic [7:0]  in_data_byte  = 8'd0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [11:0] out_code;
  logic [3:0]  out_code_bits;
  logic        out_last;
  logic        cfg_wr_en     = 1'b0;
  logic [11:0] cfg_max_code  = 12'd0;

  // encoder state
  logic [11:0] max_code;
  logic [11:0] prefix_code;
  logic        have_prefix;
  logic [12:0] next_code;
  logic [11:0] pair_codes [logic [19:0]];

  lzw_code_t   step_codes[$];
  lzw_code_t   pending_codes[$];
  int          mismatches     = 0;
  int          send_idle_pct  = 0;
  int          stall_pct      = 0;

  lzw_dictionary_compressor dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code      (out_code),
    .out_code_bits (out_code_bits),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_max_code  (cfg_max_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic lzw_code_t make_code(input logic [11:0] code, input logic last);
    lzw_code_t r;
    r.code = code;
    r.bits = 4'd1;
    for (int i = 11; i > 0; i--) begin
      if (max_code[i] && r.bits == 4'd1) begin
        r.bits = 4'(i + 1);
      end
    end
    r.last = last;
    return r;
  endfunction

  task automatic clear_pairs();
    pair_codes.delete();
    next_code = FIRST_FREE;
  endtask

  // one LZW step, codes it emits land in step_codes
  task automatic lzw_encode_step(input logic cmd, input logic [7:0] b);
    logic [19:0] key;
    step_codes.delete();
    if (cmd == CMD_END) begin
      if (have_prefix) begin
        step_codes.push_back(make_code(prefix_code, 1'b0));
      end
      step_codes.push_back(make_code(END_CODE, 1'b1));
      prefix_code = 12'd0;
      have_prefix = 1'b0;
      clear_pairs();
    end else if (!have_prefix) begin
      prefix_code = {4'd0, b};
      have_prefix = 1'b1;
    end else begin
      key = {prefix_code, b};
      if (pair_codes.exists(key)) begin
        prefix_code = pair_codes[key];
      end else begin
        step_codes.push_back(make_code(prefix_code, 1'b0));
        pair_codes[key] = next_code[11:0];
        next_code = next_code + 13'd1;
        if (next_code > {1'b0, max_code}) begin
          clear_pairs();
        end
        prefix_code = {4'd0, b};
      end
    end
  endtask

  // entered and left just after a falling edge
  task automatic send_item(input stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= row.cmd;
    in_data_byte <= row.data;
    do @(posedge clk); while (in_stall);
    lzw_encode_step(row.cmd, row.data);
    if (row.typed) begin
      if (row.n > 0) pending_codes.push_back(make_code(row.c0, row.l0));
      if (row.n > 1) pending_codes.push_back(make_code(row.c1, row.l1));
    end else begin
      foreach (step_codes[i]) pending_codes.push_back(step_codes[i]);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    lzw_code_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected transaction: code %0d bits %0d last %0b",
                   out_code, out_code_bits, out_last);
        end
      end else begin
        want = pending_codes.pop_front();
        if (out_code != want.code || out_code_bits != want.bits ||
            out_last != want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: code %0d/%0d bits %0d/%0d last %0b/%0b (want/got)",
                     want.code, out_code, want.bits, out_code_bits,
                     want.last, out_last);
          end
        end
      end
    end
  end

  initial begin
    int        phase_size [NUM_PHASES];
    int        phase_idle [NUM_PHASES];
    int        phase_stall [NUM_PHASES];
    int        phase_end [NUM_PHASES];
    int        alpha_base;
    int        alpha_span;
    stim_row_t row;

    // sizes: default, largest (long stream), then lowered mid-stream, tiny ones, largest again, random last
    phase_size  = '{1000, 4095, 300, 0, 257, 256, 4095, 0};
    phase_idle  = '{0, 77, 0, 25, 0, 77, 0, 25};
    phase_stall = '{0, 0, 77, 25, 0, 0, 77, 25};
    phase_end   = '{30, 0, 30, 30, 30, 30, 30, 30};
    phase_size[NUM_PHASES-1] = $urandom_range(4095, 300);

    max_code    = MAX_CODE_RST;
    prefix_code = 12'd0;
    have_prefix = 1'b0;
    clear_pairs();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_item(DIRECTED[i]);

    alpha_base = 0;
    alpha_span = 3;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      cfg_wr_en     <= 1'b1;
      cfg_max_code  <= 12'(phase_size[p]);
      @(negedge clk);
      cfg_wr_en     <= 1'b0;
      max_code       = 12'(phase_size[p]);
      send_idle_pct  = phase_idle[p];
      stall_pct      = phase_stall[p];
      repeat (PHASE_ITEMS) begin
        row = '0;
        if ($urandom_range(999) < phase_end[p]) begin
          row.cmd  = CMD_END;
          row.data = 8'($urandom_range(255));
          // new stream, new alphabet
          alpha_base = $urandom_range(255);
          alpha_span = $urandom_range(5, 1);
        end else if ($urandom_range(99) < 85) begin
          row.cmd  = CMD_BYTE;
          row.data = 8'(alpha_base + $urandom_range(alpha_span));
        end else begin
          row.cmd  = CMD_BYTE;
          row.data = 8'($urandom_range(255));
        end
        send_item(row);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/lzwc_pkg.sv
sv/lzwc_ram.sv
sv/lzwc_front.sv
sv/lzwc_back.sv
sv/lzw_dictionary_compressor.sv
sv/lzwc_checker.sv
tb/tb.sv
